// ===== design/hashed_value_noise_3d_defines.svh =====
// Assertion macros used by the top level of the noise pipeline.
// No dependencies.
`ifndef HASHED_VALUE_NOISE_3D_DEFINES_SVH
`define HASHED_VALUE_NOISE_3D_DEFINES_SVH
// Implication checked every clock, off during reset.
`define HVN_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define HVN_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// ===== design/hvn_pkg.sv =====
// Shared constants and a helper function for the hashed value noise pipeline.
// No dependencies.
package hvn_pkg;
	localparam logic [31:0] MIX_K1 = 32'h7feb352d;
	localparam logic [31:0] MIX_K2 = 32'h846ca68b;
	localparam logic [31:0] SALT_Y = 32'h9e3779b9;
	localparam logic [31:0] SALT_Z = 32'h85ebca6b;
	localparam logic [31:0] SALT_S = 32'hc2b2ae35;
	localparam logic [17:0] ONE_Q16 = 18'd65536;
	localparam logic [0:0] CFG_SCALE = 1'b0;
	localparam logic [0:0] CFG_SEED = 1'b1;

	// Corner value from final hash: (h >> 15) - 65536, Q1.16.
	function automatic logic signed [17:0] corner_val(input logic [31:0] h);
		corner_val = $signed({1'b0, h[31:15]}) - $signed(18'sd65536);
	endfunction
endpackage

// ===== design/hvn_mixer.sv =====
// Pipelined 32-bit hash mixer: five register stages, with multiplies in stages two and four.
// Depends on hvn_pkg.
module hvn_mixer (
	input  logic        clk,
	input  logic [31:0] din,
	output logic [31:0] dout
);
	logic [31:0] a_s1, b_s2, c_s3, d_s4, e_s5;

	always_ff @(posedge clk) begin
		a_s1 <= din ^ (din >> 16);
		b_s2 <= a_s1 * hvn_pkg::MIX_K1;
		c_s3 <= b_s2 ^ (b_s2 >> 15);
		d_s4 <= c_s3 * hvn_pkg::MIX_K2;
		e_s5 <= d_s4 ^ (d_s4 >> 16);
	end
	assign dout = e_s5;
endmodule

// ===== design/hvn_split.sv =====
// Scale one coordinate, split into cell and fraction, apply quintic fade.
// No dependencies. The cell leaves through cell_s5, the weight through w_s6.
module hvn_split (
	input  logic               clk,
	input  logic signed [15:0] dir,
	input  logic [10:0]        scale,
	output logic [31:0]        lattice,
	output logic [16:0]        weight
);
	logic signed [27:0] p_s1;
	logic [31:0] cell_s2, cell_s3, cell_s4, cell_s5;
	logic [15:0] f_s2, f_s3;
	logic [31:0] ff_s3;
	logic [15:0] t2_s4;
	logic signed [20:0] q_s4;
	logic [15:0] f_s4;
	logic [31:0] t3p_s5;
	logic signed [20:0] q_s5;
	logic [16:0] w_s6;
	logic [15:0] t3_c;
	logic [36:0] wp_c;
	logic [34:0] ff6_c;
	logic [19:0] f15_c;

	// q polynomial terms: 6*f^2 and 15*f
	assign ff6_c = {3'b0, ff_s3} * 35'd6;
	assign f15_c = {4'b0, f_s3} * 20'd15;

	always_ff @(posedge clk) begin
		// scale multiply
		p_s1 <= dir * $signed({1'b0, scale});
		// floor and fraction
		cell_s2 <= {{26{p_s1[27]}}, p_s1[27:22]};
		f_s2 <= p_s1[21:6];
		// f*f
		cell_s3 <= cell_s2;
		f_s3 <= f_s2;
		ff_s3 <= f_s2 * f_s2;
		// q polynomial and f^2
		cell_s4 <= cell_s3;
		f_s4 <= f_s3;
		t2_s4 <= ff_s3[31:16];
		q_s4 <= $signed({2'b0, ff6_c[34:16]}) - $signed({1'b0, f15_c}) + 21'sd655360;
		// f^3
		cell_s5 <= cell_s4;
		t3p_s5 <= t2_s4 * f_s4;
		q_s5 <= q_s4;
	end

	// weight = t3*q >> 16, clamped
	assign t3_c = t3p_s5[31:16];
	assign wp_c = q_s5[20] ? 37'd0 : {21'd0, t3_c} * {16'd0, q_s5[20:0]};
	always_ff @(posedge clk) begin
		w_s6 <= (wp_c[36:16] > 21'd65536) ? 17'd65536 : wp_c[32:16];
	end
	assign lattice = cell_s5;
	assign weight = w_s6;
endmodule

// ===== design/hvn_lerp.sv =====
// Registered lerp: floor((a*(1-w) + b*w) / 2^16), Q1.16 values, unsigned Q1.16 weight.
// Depends on hvn_pkg. The products are registered, then the sum.
module hvn_lerp (
	input  logic               clk,
	input  logic signed [17:0] a,
	input  logic signed [17:0] b,
	input  logic [16:0]        w,
	output logic signed [17:0] y
);
	logic signed [36:0] pa_s1, pb_s1;
	logic signed [17:0] y_s2;
	logic signed [37:0] sum_c;

	always_ff @(posedge clk) begin
		pa_s1 <= a * $signed({1'b0, hvn_pkg::ONE_Q16 - {1'b0, w}});
		pb_s1 <= b * $signed({2'b0, w});
	end
	assign sum_c = {pa_s1[36], pa_s1} + {pb_s1[36], pb_s1};
	always_ff @(posedge clk) begin
		y_s2 <= sum_c[33:16];
	end
	assign y = y_s2;
endmodule

// ===== design/hashed_value_noise_3d.sv =====
// Top level of the hashed value noise pipeline.
// Depends on hvn_pkg, hvn_split, hvn_mixer, hvn_lerp and the defines header.
`include "hashed_value_noise_3d_defines.svh"
// One transaction is taken in every cycle and each result appears on
// noise_value with done high for one cycle, after these steps in order:
// scaling and the cell split (the fade runs alongside), two mixer
// passes with an xor stage between them, and three lerps.
// The receiver cannot stall, and busy stays low.
// Write configuration only while no transaction is in flight.
module hashed_value_noise_3d (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               done,
	output logic signed [17:0] noise_value
);
	localparam int LAT = 22;
	logic [10:0] scale_q;
	logic [31:0] seed_q;
	logic [LAT-1:0] vld_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 11'd256;
			seed_q <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hvn_pkg::CFG_SCALE: scale_q <= cfg_data[10:0];
				hvn_pkg::CFG_SEED: seed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid shift line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[LAT-2:0], start & ~busy};
	end
	assign busy = 1'b0;

	logic [31:0] cx, cy, cz;
	logic [16:0] wx, wy, wz;
	hvn_split u_sx (.clk, .dir(dir_x), .scale(scale_q), .lattice(cx), .weight(wx));
	hvn_split u_sy (.clk, .dir(dir_y), .scale(scale_q), .lattice(cy), .weight(wy));
	hvn_split u_sz (.clk, .dir(dir_z), .scale(scale_q), .lattice(cz), .weight(wz));

	// first-level mixers: x, x+1, y, y+1, z, z+1, seed
	logic [31:0] m1_in [7], m1_out [7];
	assign m1_in[0] = cx;
	assign m1_in[1] = cx + 32'd1;
	assign m1_in[2] = cy + hvn_pkg::SALT_Y;
	assign m1_in[3] = cy + 32'd1 + hvn_pkg::SALT_Y;
	assign m1_in[4] = cz + hvn_pkg::SALT_Z;
	assign m1_in[5] = cz + 32'd1 + hvn_pkg::SALT_Z;
	assign m1_in[6] = seed_q + hvn_pkg::SALT_S;
	for (genvar i = 0; i < 7; i++) begin : g_m1
		hvn_mixer u_m (.clk, .din(m1_in[i]), .dout(m1_out[i]));
	end

	// weights delayed to line up with corner values
	logic [16:0] wx_d [10], wy_d [12], wz_d [14];
	always_ff @(posedge clk) begin
		wx_d[0] <= wx; wy_d[0] <= wy; wz_d[0] <= wz;
		for (int i = 1; i < 10; i++) wx_d[i] <= wx_d[i-1];
		for (int i = 1; i < 12; i++) wy_d[i] <= wy_d[i-1];
		for (int i = 1; i < 14; i++) wz_d[i] <= wz_d[i-1];
	end

	// xor stage and second mixer per corner; corner index = x + 2y + 4z
	logic [31:0] x_s1 [8], h2 [8];
	logic signed [17:0] cv [8];
	always_ff @(posedge clk) begin
		for (int c = 0; c < 8; c++)
			x_s1[c] <= m1_out[c[0]] ^ m1_out[2 + c[1]] ^ m1_out[4 + c[2]] ^ m1_out[6];
	end
	for (genvar c = 0; c < 8; c++) begin : g_m2
		hvn_mixer u_m (.clk, .din(x_s1[c]), .dout(h2[c]));
		assign cv[c] = hvn_pkg::corner_val(h2[c]);
	end

	// lerp tree: x, then y, then z
	logic signed [17:0] xl [4], yl [2];
	for (genvar j = 0; j < 4; j++) begin : g_lx
		hvn_lerp u_l (.clk, .a(cv[2*j]), .b(cv[2*j+1]), .w(wx_d[9]), .y(xl[j]));
	end
	for (genvar k = 0; k < 2; k++) begin : g_ly
		hvn_lerp u_l (.clk, .a(xl[2*k]), .b(xl[2*k+1]), .w(wy_d[11]), .y(yl[k]));
	end
	hvn_lerp u_lz (.clk, .a(yl[0]), .b(yl[1]), .w(wz_d[13]), .y(noise_value));

	assign done = vld_q[LAT-1];

	`HVN_ASSERT_IMP(a_busy_low, clk, arst_n, 1'b1, !busy)
	`HVN_ASSERT_NEXT(a_done_lat, clk, arst_n, vld_q[LAT-2], done)
	`HVN_ASSERT_IMP(a_out_range, clk, arst_n, done, (noise_value >= -18'sd65536) && (noise_value <= 18'sd65535))
endmodule
